>>> rtl/egadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding gather-add package
// Shared constants, codes and the issue descriptor passed between the
// sequencer and the output stage.
// ----------------------------------------------------------------------------
package egadd_pkg;

  localparam int unsigned VOCAB_MAX = 4096;
  localparam int unsigned DIM_MAX   = 256;
  localparam int unsigned POS_MAX   = 1024;
  localparam int unsigned LANES     = 4;

  localparam int unsigned OUT_LANES = 4;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned ECNT_W    = 9;
  localparam int unsigned RCNT_W    = 6;

  localparam logic [12:0] VOCAB_RST   = 13'd4096;
  localparam logic [8:0]  DIM_RST     = 9'd256;
  localparam logic [10:0] POS_CNT_RST = 11'd1024;
  localparam logic        USE_POS_RST = 1'b1;

  typedef enum logic [2:0] {
    FUNC_WR_TOK = 3'd0,
    FUNC_WR_POS = 3'd1,
    FUNC_SUM    = 3'd2,
    FUNC_TOK    = 3'd3,
    FUNC_POS    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_NO_POS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_VOCAB   = 2'd0,
    CFG_DIM     = 2'd1,
    CFG_POS_CNT = 2'd2,
    CFG_USE_POS = 2'd3
  } cfg_e;

  typedef struct packed {
    logic       valid;
    status_e    status;
    logic [2:0] cnt;
    logic       last;
    logic       use_tok;
    logic       use_pos;
    logic [1:0] e0;
  } issue_t;

endpackage

>>> rtl/egadd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module egadd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/egadd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding gather-add sequencer
// Holds the configuration registers, decodes each input transaction and issues
// table writes or one row group read per cycle while the output grants credit.
// ----------------------------------------------------------------------------
module egadd_ctrl #(
  parameter int unsigned VocabMax = egadd_pkg::VOCAB_MAX,
  parameter int unsigned DimMax   = egadd_pkg::DIM_MAX,
  parameter int unsigned PosMax   = egadd_pkg::POS_MAX,
  parameter int unsigned Lanes    = egadd_pkg::LANES,
  localparam int unsigned VW = (VocabMax > 1) ? $clog2(VocabMax) : 1,
  localparam int unsigned PW = (PosMax > 1) ? $clog2(PosMax) : 1,
  localparam int unsigned EW = ($clog2(DimMax) > 2) ? $clog2(DimMax) : 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [2:0]                      func_i,
  input  logic [15:0]                     token_i,
  input  logic [15:0]                     position_i,
  input  logic [7:0]                      elem_i,
  input  logic [15:0]                     wval_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [12:0]                     cfg_wdata_i,
  input  logic                            issue_ok_i,
  output egadd_pkg::issue_t               iss_o,
  output logic                            tok_we_o,
  output logic                            pos_we_o,
  output logic [VW-1:0]                   tok_row_o,
  output logic [PW-1:0]                   pos_row_o,
  output logic [EW-1:0]                   elem_o,
  output logic [egadd_pkg::ECNT_W-1:0]    e_o,
  output logic [15:0]                     wval_o
);

  localparam int unsigned Group = (Lanes < 1) ? 1 :
                                  ((Lanes > egadd_pkg::OUT_LANES) ? egadd_pkg::OUT_LANES : Lanes);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [12:0] vocab_q;
  logic [8:0]  dim_q;
  logic [10:0] pcnt_q;
  logic        cfg_use_pos_q;

  logic                            simple_q, simple_d;
  egadd_pkg::status_e              status_q, status_d;
  logic                            wtok_q, wtok_d;
  logic                            wpos_q, wpos_d;
  logic                            use_tok_q, use_tok_d;
  logic                            use_pos_q, use_pos_d;
  logic [VW-1:0]                   tok_q, tok_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic [EW-1:0]                   elem_q, elem_d;
  logic [15:0]                     wval_q, wval_d;
  logic [egadd_pkg::ECNT_W-1:0]    e_q, e_d;
  logic [egadd_pkg::RCNT_W-1:0]    n_q, n_d;

  logic [16:0] nv, np_sat, np, pos_cl;
  logic [8:0]  nd, rem;
  logic        tok_oob, pos_oob, elem_oob;
  logic [2:0]  grp_cnt;
  logic        grp_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vocab_q       <= egadd_pkg::VOCAB_RST;
      dim_q         <= egadd_pkg::DIM_RST;
      pcnt_q        <= egadd_pkg::POS_CNT_RST;
      cfg_use_pos_q <= egadd_pkg::USE_POS_RST;
    end else if (cfg_we_i) begin
      case (egadd_pkg::cfg_e'(cfg_idx_i))
        egadd_pkg::CFG_VOCAB:   vocab_q       <= cfg_wdata_i;
        egadd_pkg::CFG_DIM:     dim_q         <= cfg_wdata_i[8:0];
        egadd_pkg::CFG_POS_CNT: pcnt_q        <= cfg_wdata_i[10:0];
        egadd_pkg::CFG_USE_POS: cfg_use_pos_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign nv       = (17'(vocab_q) > 17'(VocabMax)) ? 17'(VocabMax) : 17'(vocab_q);
  assign np_sat   = (17'(pcnt_q) > 17'(PosMax)) ? 17'(PosMax) : 17'(pcnt_q);
  assign np       = (np_sat == 17'd0) ? 17'd1 : np_sat;
  assign nd       = (dim_q > 9'(DimMax)) ? 9'(DimMax) : dim_q;
  assign tok_oob  = {1'b0, token_i} >= nv;
  assign pos_oob  = {1'b0, position_i} >= np;
  assign elem_oob = {1'b0, elem_i} >= nd;
  assign pos_cl   = pos_oob ? (np - 17'd1) : {1'b0, position_i};

  assign rem      = nd - e_q;
  assign grp_cnt  = (rem > 9'(Group)) ? 3'(Group) : rem[2:0];
  assign grp_last = (rem <= 9'(Group)) || (n_q == {egadd_pkg::RCNT_W{1'b1}});

  always_comb begin
    state_d   = state_q;
    simple_d  = simple_q;
    status_d  = status_q;
    wtok_d    = wtok_q;
    wpos_d    = wpos_q;
    use_tok_d = use_tok_q;
    use_pos_d = use_pos_q;
    tok_d     = tok_q;
    pos_d     = pos_q;
    elem_d    = elem_q;
    wval_d    = wval_q;
    e_d       = e_q;
    n_d       = n_q;
    iss_o     = '0;
    tok_we_o  = 1'b0;
    pos_we_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          tok_d     = token_i[VW-1:0];
          pos_d     = pos_cl[PW-1:0];
          elem_d    = elem_i[EW-1:0];
          wval_d    = wval_i;
          e_d       = '0;
          n_d       = '0;
          wtok_d    = 1'b0;
          wpos_d    = 1'b0;
          use_tok_d = 1'b0;
          use_pos_d = 1'b0;
          simple_d  = 1'b1;
          status_d  = egadd_pkg::ST_OK;
          state_d   = S_RUN;
          case (egadd_pkg::func_e'(func_i))
            egadd_pkg::FUNC_WR_TOK: begin
              status_d = (tok_oob || elem_oob) ? egadd_pkg::ST_BOUNDS : egadd_pkg::ST_OK;
              wtok_d   = !(tok_oob || elem_oob);
            end
            egadd_pkg::FUNC_WR_POS: begin
              status_d = (pos_oob || elem_oob) ? egadd_pkg::ST_BOUNDS : egadd_pkg::ST_OK;
              wpos_d   = !(pos_oob || elem_oob);
            end
            egadd_pkg::FUNC_SUM, egadd_pkg::FUNC_TOK: begin
              if (tok_oob) begin
                status_d = egadd_pkg::ST_BOUNDS;
              end else if (nd != 9'd0) begin
                simple_d  = 1'b0;
                use_tok_d = 1'b1;
                use_pos_d = (func_i == egadd_pkg::FUNC_SUM) && cfg_use_pos_q;
              end
            end
            egadd_pkg::FUNC_POS: begin
              if (!cfg_use_pos_q) begin
                status_d = egadd_pkg::ST_NO_POS;
              end else if (nd != 9'd0) begin
                simple_d  = 1'b0;
                use_pos_d = 1'b1;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RUN: begin
        if (issue_ok_i) begin
          iss_o.valid = 1'b1;
          if (simple_q) begin
            iss_o.status = status_q;
            iss_o.last   = 1'b1;
            tok_we_o     = wtok_q;
            pos_we_o     = wpos_q;
            state_d      = S_IDLE;
          end else begin
            iss_o.status  = egadd_pkg::ST_OK;
            iss_o.cnt     = grp_cnt;
            iss_o.last    = grp_last;
            iss_o.use_tok = use_tok_q;
            iss_o.use_pos = use_pos_q;
            iss_o.e0      = e_q[1:0];
            e_d           = e_q + egadd_pkg::ECNT_W'(Group);
            n_d           = n_q + egadd_pkg::RCNT_W'(1);
            if (grp_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    simple_q  <= simple_d;
    status_q  <= status_d;
    wtok_q    <= wtok_d;
    wpos_q    <= wpos_d;
    use_tok_q <= use_tok_d;
    use_pos_q <= use_pos_d;
    tok_q     <= tok_d;
    pos_q     <= pos_d;
    elem_q    <= elem_d;
    wval_q    <= wval_d;
    e_q       <= e_d;
    n_q       <= n_d;
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign tok_row_o = tok_q;
  assign pos_row_o = pos_q;
  assign elem_o    = elem_q;
  assign e_o       = e_q;
  assign wval_o    = wval_q;

endmodule

>>> rtl/egadd_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding gather-add output stage
// Aligns the bank read data to lanes, adds and saturates, and buffers the
// results in a two-entry queue that grants issue credit to the sequencer.
// ----------------------------------------------------------------------------
module egadd_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  egadd_pkg::issue_t      iss_i,
  input  logic [3:0][15:0]       tok_rdata_i,
  input  logic [3:0][15:0]       pos_rdata_i,
  output logic                   issue_ok_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output egadd_pkg::status_e     status_o,
  output logic [3:0][15:0]       lanes_o,
  output logic [2:0]             lanes_valid_o,
  output logic                   last_o
);

  typedef struct packed {
    egadd_pkg::status_e status;
    logic [3:0][15:0]   lanes;
    logic [2:0]         lanes_valid;
    logic               last;
  } result_t;

  egadd_pkg::issue_t d1_q;
  result_t           res;
  result_t           fifo_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;
  logic              push, pop;
  logic [2:0]        occ;

  always_comb begin
    logic [1:0]  sel;
    logic [15:0] t, p;
    logic [16:0] sum;
    res.status      = d1_q.status;
    res.lanes_valid = d1_q.cnt;
    res.last        = d1_q.last;
    res.lanes       = '0;
    for (int k = 0; k < 4; k++) begin
      sel = d1_q.e0 + 2'(k);
      t   = d1_q.use_tok ? tok_rdata_i[sel] : 16'd0;
      p   = d1_q.use_pos ? pos_rdata_i[sel] : 16'd0;
      sum = {t[15], t} + {p[15], p};
      if (3'(k) < d1_q.cnt) begin
        if (sum[16] != sum[15]) begin
          res.lanes[k] = sum[16] ? 16'h8000 : 16'h7FFF;
        end else begin
          res.lanes[k] = sum[15:0];
        end
      end
    end
  end

  assign push       = d1_q.valid;
  assign pop        = m_valid_o && m_ready_i;
  assign occ        = 3'(cnt_q) + 3'(d1_q.valid);
  assign issue_ok_o = occ <= (3'd1 + 3'(pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q  <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      d1_q  <= iss_i;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res;
    end
  end

  assign m_valid_o     = (cnt_q != 2'd0);
  assign status_o      = fifo_q[rd_q].status;
  assign lanes_o       = fifo_q[rd_q].lanes;
  assign lanes_valid_o = fifo_q[rd_q].lanes_valid;
  assign last_o        = fifo_q[rd_q].last;

endmodule

>>> rtl/embedding_gather_add.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding gather-add
// Token and position embedding tables in banked RAM; a lookup streams the
// token row, the position row or their saturated sum, four lanes per result.
// ----------------------------------------------------------------------------
// The first result of a transaction passes the sequencer registers, the bank
// read registers and the output queue. A lookup issues one group per cycle
// from four RAM banks per table while the output queue grants credit, in all
// ceil(dim / group) groups, at most 64; writes, acks and errors give a single
// result. Reset sets the configuration registers to their defaults; the table contents stay undefined until written.
module embedding_gather_add #(
  parameter int unsigned VocabMax = egadd_pkg::VOCAB_MAX,
  parameter int unsigned DimMax   = egadd_pkg::DIM_MAX,
  parameter int unsigned PosMax   = egadd_pkg::POS_MAX,
  parameter int unsigned Lanes    = egadd_pkg::LANES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // token [15:0], position [31:16], elem_index [39:32], write_value [55:40]
  input  logic [55:0] s_axis_tdata,
  // func [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // lane0 [15:0], lane1 [31:16], lane2 [47:32], lane3 [63:48],
  // lanes_valid [66:64], zero padding [71:67]
  output logic [71:0] m_axis_tdata,
  // status [1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i
);

  localparam int unsigned VW = (VocabMax > 1) ? $clog2(VocabMax) : 1;
  localparam int unsigned PW = (PosMax > 1) ? $clog2(PosMax) : 1;
  localparam int unsigned EW = ($clog2(DimMax) > 2) ? $clog2(DimMax) : 3;
  localparam int unsigned CW = EW - 2;
  localparam int unsigned TokDepth = 1 << (VW + CW);
  localparam int unsigned PosDepth = 1 << (PW + CW);

  egadd_pkg::issue_t            iss;
  logic                         issue_ok;
  logic                         tok_we, pos_we;
  logic [VW-1:0]                tok_row;
  logic [PW-1:0]                pos_row;
  logic [EW-1:0]                elem;
  logic [egadd_pkg::ECNT_W-1:0] e;
  logic [15:0]                  wval;
  logic [3:0][15:0]             tok_rdata, pos_rdata, lanes;
  logic [2:0]                   lanes_valid;
  egadd_pkg::status_e           status;

  egadd_ctrl #(
    .VocabMax (VocabMax),
    .DimMax   (DimMax),
    .PosMax   (PosMax),
    .Lanes    (Lanes)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .func_i      (s_axis_tuser),
    .token_i     (s_axis_tdata[15:0]),
    .position_i  (s_axis_tdata[31:16]),
    .elem_i      (s_axis_tdata[39:32]),
    .wval_i      (s_axis_tdata[55:40]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .issue_ok_i  (issue_ok),
    .iss_o       (iss),
    .tok_we_o    (tok_we),
    .pos_we_o    (pos_we),
    .tok_row_o   (tok_row),
    .pos_row_o   (pos_row),
    .elem_o      (elem),
    .e_o         (e),
    .wval_o      (wval)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [1:0]                   k;
    logic [egadd_pkg::ECNT_W-1:0] idx;
    logic                         sel_w;

    assign k     = 2'(b) - iss.e0;
    assign idx   = e + egadd_pkg::ECNT_W'(k);
    assign sel_w = (elem[1:0] == 2'(b));

    egadd_ram #(
      .Width (egadd_pkg::ELEM_W),
      .Depth (TokDepth)
    ) u_tok_ram (
      .clk_i   (clk_i),
      .we_i    (tok_we && sel_w),
      .waddr_i ({tok_row, elem[EW-1:2]}),
      .wdata_i (wval),
      .re_i    (iss.valid),
      .raddr_i ({tok_row, idx[EW-1:2]}),
      .rdata_o (tok_rdata[b])
    );

    egadd_ram #(
      .Width (egadd_pkg::ELEM_W),
      .Depth (PosDepth)
    ) u_pos_ram (
      .clk_i   (clk_i),
      .we_i    (pos_we && sel_w),
      .waddr_i ({pos_row, elem[EW-1:2]}),
      .wdata_i (wval),
      .re_i    (iss.valid),
      .raddr_i ({pos_row, idx[EW-1:2]}),
      .rdata_o (pos_rdata[b])
    );
  end

  egadd_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .iss_i         (iss),
    .tok_rdata_i   (tok_rdata),
    .pos_rdata_i   (pos_rdata),
    .issue_ok_o    (issue_ok),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .status_o      (status),
    .lanes_o       (lanes),
    .lanes_valid_o (lanes_valid),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, lanes_valid, lanes};
  assign m_axis_tuser = status;

  a_issue_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss.valid |-> issue_ok)
    else $error("group issued without output credit");

  a_group_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iss.valid && (iss.use_tok || iss.use_pos)) |-> (iss.cnt != 3'd0 && iss.cnt <= 3'd4))
    else $error("row group with an invalid lane count");

  a_single_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tok_we && pos_we))
    else $error("token and position tables written in the same cycle");

  a_write_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_we || pos_we) |-> (iss.valid && iss.last && iss.cnt == 3'd0))
    else $error("table write without its acknowledge");

endmodule

>>> tb/embedding_gather_add_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedding gather-add testbench
// Loads the token and position tables through write transactions and checks
// every result of sum, token-only and position-only lookups against a local
// prediction of the tables and registers. A short directed part covers
// saturation, position clamping, bounds errors, zero dim and a disabled
// position table. Random phases follow under changing configurations, with
// random idling on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module embedding_gather_add_tb;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned GROUP_CAP    = 64;
  localparam logic [2:0]  FUNC_BAD_FIRST = 3'd5;
  localparam logic [2:0]  FUNC_BAD_LAST  = 3'd7;

  typedef struct packed {
    egadd_pkg::status_e status;
    logic [3:0][15:0]   lanes;
    logic [2:0]         cnt;
    logic               last;
  } embed_group_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // token [15:0], position [31:16], elem_index [39:32], write_value [55:40]
  logic [55:0] s_axis_tdata;
  // func [2:0]
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // lane0 [15:0], lane1 [31:16], lane2 [47:32], lane3 [63:48],
  // lanes_valid [66:64], zero padding [71:67]
  logic [71:0] m_axis_tdata;
  // status [1:0]
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_wdata_i;

  logic [15:0]  tok_mem [int unsigned];
  logic [15:0]  pos_mem [int unsigned];
  logic [12:0]  vocab_reg   = egadd_pkg::VOCAB_RST;
  logic [8:0]   dim_reg     = egadd_pkg::DIM_RST;
  logic [10:0]  poscnt_reg  = egadd_pkg::POS_CNT_RST;
  logic         use_pos_reg = egadd_pkg::USE_POS_RST;
  embed_group_t pending_groups [$];
  int unsigned  tok_rows [$];
  int unsigned  pos_rows [$];
  embed_group_t want_group;
  int           lane_i;
  int unsigned  fail_count     = 0;
  int unsigned  accepted_items = 0;
  int unsigned  cycle_count    = 0;
  bit           no_idle        = 1'b0;

  embedding_gather_add u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned eff_vocab();
    return (32'(vocab_reg) > egadd_pkg::VOCAB_MAX) ? egadd_pkg::VOCAB_MAX : 32'(vocab_reg);
  endfunction

  function automatic int unsigned eff_dim();
    return (32'(dim_reg) > egadd_pkg::DIM_MAX) ? egadd_pkg::DIM_MAX : 32'(dim_reg);
  endfunction

  function automatic int unsigned eff_pos();
    int unsigned np;
    np = (32'(poscnt_reg) > egadd_pkg::POS_MAX) ? egadd_pkg::POS_MAX : 32'(poscnt_reg);
    return (np == 0) ? 1 : np;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_status_only(input egadd_pkg::status_e st);
    embed_group_t g;
    g = '0;
    g.status = st;
    g.last = 1'b1;
    pending_groups.push_back(g);
  endtask

  task automatic push_row_groups(input int unsigned tok, input int unsigned pos,
                                 input bit add_tok, input bit add_pos);
    embed_group_t g;
    int unsigned  nd, e, n, k;
    int           acc;
    nd = eff_dim();
    e = 0;
    n = 0;
    if (nd == 0) begin
      push_status_only(egadd_pkg::ST_OK);
      return;
    end
    while (e < nd && n < GROUP_CAP) begin
      g = '0;
      g.status = egadd_pkg::ST_OK;
      for (k = 0; k < egadd_pkg::OUT_LANES; k++) begin
        if (e < nd) begin
          acc = 0;
          if (add_tok) acc = int'($signed(tok_mem[tok * egadd_pkg::DIM_MAX + e]));
          if (add_pos) acc += int'($signed(pos_mem[pos * egadd_pkg::DIM_MAX + e]));
          if (acc > 32767) acc = 32767;
          else if (acc < -32768) acc = -32768;
          g.lanes[k] = acc[15:0];
          g.cnt = g.cnt + 3'd1;
          e++;
        end
      end
      n++;
      g.last = (e >= nd || n == GROUP_CAP);
      pending_groups.push_back(g);
    end
  endtask

  task automatic apply_embed_item(input logic [2:0] fn, input logic [15:0] tok,
                                  input logic [15:0] pos, input logic [7:0] elem,
                                  input logic [15:0] val);
    int unsigned nv, nd, np, p;
    nv = eff_vocab();
    nd = eff_dim();
    np = eff_pos();
    p = (32'(pos) >= np) ? np - 1 : 32'(pos);
    case (fn)
      egadd_pkg::FUNC_WR_TOK: begin
        if (32'(tok) >= nv || 32'(elem) >= nd) begin
          push_status_only(egadd_pkg::ST_BOUNDS);
        end else begin
          tok_mem[32'(tok) * egadd_pkg::DIM_MAX + 32'(elem)] = val;
          push_status_only(egadd_pkg::ST_OK);
        end
      end
      egadd_pkg::FUNC_WR_POS: begin
        if (32'(pos) >= np || 32'(elem) >= nd) begin
          push_status_only(egadd_pkg::ST_BOUNDS);
        end else begin
          pos_mem[32'(pos) * egadd_pkg::DIM_MAX + 32'(elem)] = val;
          push_status_only(egadd_pkg::ST_OK);
        end
      end
      egadd_pkg::FUNC_SUM, egadd_pkg::FUNC_TOK: begin
        if (32'(tok) >= nv) push_status_only(egadd_pkg::ST_BOUNDS);
        else push_row_groups(32'(tok), p, 1'b1, fn == egadd_pkg::FUNC_SUM && use_pos_reg);
      end
      egadd_pkg::FUNC_POS: begin
        if (!use_pos_reg) push_status_only(egadd_pkg::ST_NO_POS);
        else push_row_groups(0, p, 1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [2:0] fn, input logic [15:0] tok,
                           input logic [15:0] pos, input logic [7:0] elem,
                           input logic [15:0] val);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {val, elem, pos, tok};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_embed_item(fn, tok, pos, elem, val);
    if (fn <= egadd_pkg::FUNC_POS) accepted_items++;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_groups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [12:0] vocab, input logic [12:0] dim,
                            input logic [12:0] pcnt, input logic [12:0] use_p);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= egadd_pkg::CFG_VOCAB;
    cfg_wdata_i <= vocab;
    @(posedge clk_i);
    cfg_idx_i   <= egadd_pkg::CFG_DIM;
    cfg_wdata_i <= dim;
    @(posedge clk_i);
    cfg_idx_i   <= egadd_pkg::CFG_POS_CNT;
    cfg_wdata_i <= pcnt;
    @(posedge clk_i);
    cfg_idx_i   <= egadd_pkg::CFG_USE_POS;
    cfg_wdata_i <= use_p;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vocab_reg   = vocab;
    dim_reg     = dim[8:0];
    poscnt_reg  = pcnt[10:0];
    use_pos_reg = use_p[0];
  endtask

  task automatic send_noise(input int unsigned nv, input int unsigned nd,
                            input int unsigned np);
    case ($urandom_range(0, 3))
      0: send_item(egadd_pkg::FUNC_WR_TOK, 16'($urandom_range(nv, 65535)), 16'($urandom),
                   8'($urandom), 16'($urandom));
      1: begin
        if (nd < egadd_pkg::DIM_MAX) begin
          send_item(egadd_pkg::FUNC_WR_TOK, 16'($urandom_range(0, nv - 1)), 16'($urandom),
                    8'($urandom_range(nd, 255)), 16'($urandom));
        end else begin
          send_item(egadd_pkg::FUNC_WR_POS, 16'($urandom), 16'($urandom_range(np, 65535)),
                    8'($urandom), 16'($urandom));
        end
      end
      2: send_item(egadd_pkg::FUNC_WR_POS, 16'($urandom), 16'($urandom_range(np, 65535)),
                   8'($urandom), 16'($urandom));
      default: begin
        send_item(3'($urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST)), 16'($urandom),
                  16'($urandom), 8'($urandom), 16'($urandom));
      end
    endcase
  endtask

  task automatic load_row(input bit is_pos, input int unsigned row, input int unsigned nv,
                          input int unsigned nd, input int unsigned np);
    int unsigned e;
    for (e = 0; e < nd; e++) begin
      if ($urandom_range(0, 9) == 0) send_noise(nv, nd, np);
      if (is_pos) begin
        send_item(egadd_pkg::FUNC_WR_POS, 16'($urandom), 16'(row), 8'(e), 16'($urandom));
      end else begin
        send_item(egadd_pkg::FUNC_WR_TOK, 16'(row), 16'($urandom), 8'(e), 16'($urandom));
      end
    end
  endtask

  // Any position at or beyond the count clamps to the last row, which is
  // always loaded, so both choices read written entries only.
  function automatic logic [15:0] pick_position(input int unsigned np);
    if ($urandom_range(0, 1) == 0) begin
      return 16'(pos_rows[$urandom_range(0, pos_rows.size() - 1)]);
    end
    return 16'($urandom_range(np, 65535));
  endfunction

  task automatic run_phase(input logic [12:0] vocab, input logic [12:0] dim,
                           input logic [12:0] pcnt, input logic [12:0] use_p);
    int unsigned nv, nd, np, row, n_lookups, r;
    logic [15:0] tok;
    wait_quiet();
    set_config(vocab, dim, pcnt, use_p);
    nv = eff_vocab();
    nd = eff_dim();
    np = eff_pos();
    tok_rows.delete();
    pos_rows.delete();
    repeat ((nd > 16) ? 1 : $urandom_range(1, 3)) begin
      row = $urandom_range(0, nv - 1);
      load_row(1'b0, row, nv, nd, np);
      tok_rows.push_back(row);
    end
    if (use_pos_reg) begin
      load_row(1'b1, np - 1, nv, nd, np);
      pos_rows.push_back(np - 1);
      if (nd <= 16) begin
        repeat ($urandom_range(0, 2)) begin
          row = $urandom_range(0, np - 1);
          load_row(1'b1, row, nv, nd, np);
          pos_rows.push_back(row);
        end
      end
    end
    n_lookups = (nd > 40) ? 6 : $urandom_range(8, 20);
    repeat (n_lookups) begin
      r = $urandom_range(0, 99);
      tok = 16'(tok_rows[$urandom_range(0, tok_rows.size() - 1)]);
      if (r < 35) begin
        send_item(egadd_pkg::FUNC_SUM, tok, use_pos_reg ? pick_position(np) : 16'($urandom),
                  8'($urandom), 16'($urandom));
      end else if (r < 60) begin
        send_item(egadd_pkg::FUNC_TOK, tok, 16'($urandom), 8'($urandom), 16'($urandom));
      end else if (r < 80) begin
        send_item(egadd_pkg::FUNC_POS, 16'($urandom),
                  use_pos_reg ? pick_position(np) : 16'($urandom),
                  8'($urandom), 16'($urandom));
      end else if (r < 90) begin
        send_item(egadd_pkg::FUNC_SUM, 16'($urandom_range(nv, 65535)), 16'($urandom),
                  8'($urandom), 16'($urandom));
      end else begin
        send_item(egadd_pkg::FUNC_TOK, 16'($urandom_range(nv, 65535)), 16'($urandom),
                  8'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_saturation_and_clamp();
    set_config(13'h1FFF, 13'd4, 13'd0, 13'd1);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd4095, 16'd0, 8'd0, 16'h7FFF);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd4095, 16'd0, 8'd1, 16'h8000);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd4095, 16'd0, 8'd2, 16'h7FFF);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd4095, 16'd0, 8'd3, 16'h0001);
    send_item(egadd_pkg::FUNC_WR_POS, 16'd0, 16'd0, 8'd0, 16'h7FFF);
    send_item(egadd_pkg::FUNC_WR_POS, 16'd0, 16'd0, 8'd1, 16'h8000);
    send_item(egadd_pkg::FUNC_WR_POS, 16'd0, 16'd0, 8'd2, 16'h8000);
    send_item(egadd_pkg::FUNC_WR_POS, 16'd0, 16'd0, 8'd3, 16'hFFFF);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd4096, 16'd0, 8'd0, 16'h1234);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd0, 16'd0, 8'd255, 16'h1234);
    send_item(egadd_pkg::FUNC_WR_POS, 16'd0, 16'd1, 8'd0, 16'h1234);
    send_item(egadd_pkg::FUNC_SUM, 16'd4095, 16'hFFFF, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_TOK, 16'd4095, 16'hFFFF, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_POS, 16'hFFFF, 16'd300, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_SUM, 16'd4096, 16'd0, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_TOK, 16'hFFFF, 16'd0, 8'd0, 16'd0);
    send_item(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(3'd6, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_item(FUNC_BAD_LAST, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_zero_dim();
    wait_quiet();
    set_config(13'h1FFF, 13'd0, 13'd0, 13'd1);
    send_item(egadd_pkg::FUNC_SUM, 16'd4095, 16'd0, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_WR_TOK, 16'd0, 16'd0, 8'd0, 16'h4321);
  endtask

  task automatic test_position_disabled();
    wait_quiet();
    set_config(13'h1FFF, 13'd4, 13'd0, 13'd0);
    send_item(egadd_pkg::FUNC_POS, 16'd0, 16'd0, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_SUM, 16'd4095, 16'd0, 8'd0, 16'd0);
    send_item(egadd_pkg::FUNC_WR_POS, 16'd0, 16'd0, 8'd3, 16'h1234);
  endtask

  task automatic test_random_phases();
    int unsigned phase, r;
    logic [12:0] vocab, dim, pcnt;
    phase = 0;
    accepted_items = 0;
    while (phase < 6 || accepted_items < RANDOM_ITEMS) begin
      no_idle = (phase % 3 == 1);
      case (phase)
        0: run_phase(13'd1, 13'd511, 13'd2047, 13'd0);
        1: run_phase(13'd4096, 13'd1, 13'd1, 13'd1);
        2: run_phase(13'h1FFF, 13'd7, 13'd1024, 13'd1);
        default: begin
          r = $urandom_range(0, 99);
          vocab = (r < 70) ? 13'($urandom_range(1, 64)) :
                  (r < 85) ? 13'($urandom_range(65, 4095)) : 13'($urandom_range(4096, 8191));
          dim = ($urandom_range(0, 99) < 85) ? 13'($urandom_range(1, 16)) :
                13'($urandom_range(17, 40));
          r = $urandom_range(0, 99);
          pcnt = (r < 20) ? 13'd0 : (r < 70) ? 13'($urandom_range(1, 64)) :
                 (r < 85) ? 13'($urandom_range(65, 1023)) : 13'($urandom_range(1024, 2047));
          run_phase(vocab, dim, pcnt, 13'($urandom_range(0, 1)));
        end
      endcase
      phase++;
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_groups.size() == 0) begin
        $error("result transaction with no pending expectation");
        fail_count++;
      end else begin
        want_group = pending_groups.pop_front();
        check_field("status", 32'(want_group.status), 32'(m_axis_tuser));
        for (lane_i = 0; lane_i < egadd_pkg::OUT_LANES; lane_i++) begin
          check_field($sformatf("lane%0d", lane_i), 32'(want_group.lanes[lane_i]),
                      32'(m_axis_tdata[16*lane_i +: 16]));
        end
        check_field("lanes_valid", 32'(want_group.cnt), 32'(m_axis_tdata[66:64]));
        check_field("last", 32'(want_group.last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    int unsigned burst, stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (no_idle) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        burst = $urandom_range(1, 12);
        m_axis_tready <= 1'b1;
        repeat (burst) @(posedge clk_i);
        stall = idle_gap();
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= egadd_pkg::FUNC_WR_TOK;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= egadd_pkg::CFG_VOCAB;
    cfg_wdata_i   <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_saturation_and_clamp();
    test_zero_dim();
    test_position_disabled();
    test_random_phases();
    wait_quiet();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
